FILE: hw/rtl/scps_pkg.sv
// Shared types and constants of the safety chime pulse scheduler.
package scps_pkg;

    // Input word action codes
    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_STATUS = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Configuration register indexes
    localparam logic [2:0] CFG_PULSE_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_CHIME_LOW    = 3'd1;
    localparam logic [2:0] CFG_CHIME_MID    = 3'd2;
    localparam logic [2:0] CFG_CHIME_HIGH   = 3'd3;
    localparam logic [2:0] CFG_SWEEP_LOW    = 3'd4;
    localparam logic [2:0] CFG_SWEEP_MID    = 3'd5;
    localparam logic [2:0] CFG_SWEEP_HIGH   = 3'd6;
    localparam logic [2:0] CFG_FRESH_TMO    = 3'd7;

    // Configuration reset values
    localparam logic [15:0] RST_PULSE_WIDTH = 16'd100;
    localparam logic [15:0] RST_CHIME_LOW   = 16'd600;
    localparam logic [15:0] RST_CHIME_MID   = 16'd300;
    localparam logic [15:0] RST_CHIME_HIGH  = 16'd150;
    localparam logic [15:0] RST_SWEEP_LOW   = 16'd10;
    localparam logic [15:0] RST_SWEEP_MID   = 16'd5;
    localparam logic [15:0] RST_SWEEP_HIGH  = 16'd2;
    localparam logic [15:0] RST_FRESH_TMO   = 16'd500;

    // Status frame acceptance and fault mapping
    localparam logic [1:0]  STATUS_BUS        = 2'd1;
    localparam logic [10:0] STATUS_ID         = 11'd1441;
    localparam logic [3:0]  MIN_LENGTH        = 4'd8;
    localparam logic [7:0]  SENSOR_FAULT_FLAG = 8'd1;
    localparam logic [7:0]  FORCED_FAULT_BITS = 8'd3;

    // Risk thresholds
    localparam logic [7:0] RISK_WARN   = 8'd2;
    localparam logic [7:0] RISK_DANGER = 8'd3;
    localparam logic [7:0] RISK_HIGH   = 8'd4;

    // Alert classes
    localparam logic [1:0] ALERT_NONE   = 2'd0;
    localparam logic [1:0] ALERT_WARN   = 2'd1;
    localparam logic [1:0] ALERT_DANGER = 2'd2;

    // Result word kinds
    localparam logic KIND_SNAP  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic check;
        logic pulse;
        logic release_frame;
        logic frame;
        logic fix;
        logic apply;
        logic snap;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic alert;
        logic was_alert;
        logic frame_due;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/scps_ctrl.sv
// Sequencing state machine of the safety chime pulse scheduler.
module scps_ctrl
    import scps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CHECK   = 8'b0000_0010,
        S_PULSE   = 8'b0000_0100,
        S_RELEASE = 8'b0000_1000,
        S_FRAME   = 8'b0001_0000,
        S_FIX     = 8'b0010_0000,
        S_APPLY   = 8'b0100_0000,
        S_SNAP    = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // Pick the next step
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action)) inside
                        ACT_TICK:              n_state = S_CHECK;
                        ACT_STATUS, ACT_CLEAR: n_state = S_APPLY;
                        default:               n_state = S_SNAP;
                    endcase
                end
            end
            S_CHECK: n_state = S_PULSE;
            S_PULSE: n_state = i_sts.alert ? S_FRAME : S_RELEASE;
            S_RELEASE: begin
                if (!i_sts.was_alert || i_sts.out_free) begin
                    n_state = S_SNAP;
                end
            end
            S_FRAME: begin
                if (!i_sts.frame_due) begin
                    n_state = S_FIX;
                end
            end
            S_FIX:   n_state = S_SNAP;
            S_APPLY: n_state = S_SNAP;
            S_SNAP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Drive the datapath commands
    always_comb begin
        o_cmd               = '0;
        o_cmd.load          = accept;
        o_cmd.check         = (r_state == S_CHECK);
        o_cmd.pulse         = (r_state == S_PULSE);
        o_cmd.release_frame = (r_state == S_RELEASE);
        o_cmd.frame         = (r_state == S_FRAME);
        o_cmd.fix           = (r_state == S_FIX);
        o_cmd.apply         = (r_state == S_APPLY);
        o_cmd.snap          = (r_state == S_SNAP);
    end

    // A tick always passes through the check before touching the pulse
    a_pulse_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PULSE) |-> $past(r_state == S_CHECK))
        else $error("pulse step without check step");

    // The frame loop only leaves toward the fixup step
    a_frame_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAME && !i_sts.frame_due && i_rst_n) |=> (r_state == S_FIX))
        else $error("frame loop left to wrong step");

    // No new word is taken until the snapshot has gone out
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SNAP && !i_sts.out_free && i_rst_n) |=> !o_in_ready)
        else $error("input accepted before snapshot was emitted");

endmodule

FILE: hw/rtl/scps_dp.sv
// Datapath of the safety chime pulse scheduler: config, state, timers, output word.
module scps_dp
    import scps_pkg::*;
#(
    parameter int MAX_BURST = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input word
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now_ms,
    input  logic [1:0]  i_bus_number,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_length,
    input  logic [7:0]  i_status_flags,
    input  logic [7:0]  i_risk_level,
    input  logic [7:0]  i_front_cm,
    input  logic [7:0]  i_rear_cm,
    input  logic [7:0]  i_fault_bits,
    // controller link
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    // result word
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic        o_chime_on,
    output logic [7:0]  o_sweep_value,
    output logic        o_last_of_run,
    output logic        o_status_valid,
    output logic [7:0]  o_risk_out,
    output logic [7:0]  o_flags_out,
    output logic [1:0]  o_alert_class,
    output logic [7:0]  o_sticky_faults,
    output logic [7:0]  o_active_faults,
    output logic [7:0]  o_front_cm_out,
    output logic [7:0]  o_rear_cm_out
);

    localparam int BW = $clog2(MAX_BURST + 1);

    // configuration
    logic [15:0] r_pulse_width, r_chime_low, r_chime_mid, r_chime_high;
    logic [15:0] r_sweep_low, r_sweep_mid, r_sweep_high, r_fresh_tmo;

    // latched input word
    t_action     r_action;
    logic [31:0] r_now;
    logic [1:0]  r_bus;
    logic [10:0] r_id;
    logic [3:0]  r_len;
    logic [7:0]  r_flags_in, r_risk_in, r_front_in, r_rear_in, r_faults_in;

    // scheduler state
    logic        r_have;
    logic [7:0]  r_risk, r_flags, r_front, r_rear, r_faults, r_sticky;
    logic [1:0]  r_alert_state;
    logic [31:0] r_last_time, r_next_pulse, r_pulse_end, r_next_frame;
    logic        r_pulse_active;
    logic [7:0]  r_sweep;
    logic        r_was_alert;
    logic        r_alert;
    logic [BW-1:0] r_burst;

    // output register
    logic        r_out_valid;
    logic        r_out_kind, r_out_chime, r_out_last, r_out_have;
    logic [7:0]  r_out_sweep, r_out_risk, r_out_flags, r_out_sticky;
    logic [7:0]  r_out_faults, r_out_front, r_out_rear;
    logic [1:0]  r_out_alert;

    // combinational helpers
    logic [31:0] age;
    logic        alert_now;
    logic [15:0] chime_per, sweep_raw, sweep_per;
    logic [31:0] pe_diff, np_diff, nf_diff;
    logic        pe_hit, np_hit, nf_hit;
    logic [31:0] np_eff;
    logic        pa_kept;
    logic        out_free;
    logic        frame_due, frame_emit, rel_go, rel_emit, snap_emit, emit;
    logic        match, sensor;

    // Freshness and risk test for alerting
    assign age       = r_now - r_last_time;
    assign alert_now = r_have && (age <= {16'd0, r_fresh_tmo}) && (r_risk >= RISK_WARN);

    // Period selection by stored risk
    always_comb begin
        if (r_risk >= RISK_HIGH) begin
            chime_per = r_chime_high;
            sweep_raw = r_sweep_high;
        end else if (r_risk >= RISK_DANGER) begin
            chime_per = r_chime_mid;
            sweep_raw = r_sweep_mid;
        end else begin
            chime_per = r_chime_low;
            sweep_raw = r_sweep_low;
        end
    end
    assign sweep_per = (sweep_raw == 16'd0) ? 16'd1 : sweep_raw;

    // Wrap-aware deadline tests
    assign pe_diff = r_now - r_pulse_end;
    assign np_diff = r_now - r_next_pulse;
    assign nf_diff = r_now - r_next_frame;
    assign pe_hit  = !pe_diff[31];
    assign np_hit  = (r_next_pulse == 32'd0) || !np_diff[31];
    assign nf_hit  = !nf_diff[31];
    assign np_eff  = (r_next_pulse == 32'd0) ? r_now : r_next_pulse;
    assign pa_kept = r_pulse_active && !pe_hit;

    // Emission control
    assign out_free   = !r_out_valid || i_out_ready;
    assign frame_due  = (r_burst < BW'(MAX_BURST)) && nf_hit;
    assign frame_emit = i_cmd.frame && frame_due && out_free;
    assign rel_go     = i_cmd.release_frame && (!r_was_alert || out_free);
    assign rel_emit   = rel_go && r_was_alert;
    assign snap_emit  = i_cmd.snap && out_free;
    assign emit       = frame_emit || rel_emit || snap_emit;

    // Status frame acceptance
    assign match  = (r_bus == STATUS_BUS) && (r_id == STATUS_ID) && (r_len >= MIN_LENGTH);
    assign sensor = |(r_flags_in & SENSOR_FAULT_FLAG);

    assign o_sts.alert     = r_alert;
    assign o_sts.was_alert = r_was_alert;
    assign o_sts.frame_due = frame_due;
    assign o_sts.out_free  = out_free;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_width <= RST_PULSE_WIDTH;
            r_chime_low   <= RST_CHIME_LOW;
            r_chime_mid   <= RST_CHIME_MID;
            r_chime_high  <= RST_CHIME_HIGH;
            r_sweep_low   <= RST_SWEEP_LOW;
            r_sweep_mid   <= RST_SWEEP_MID;
            r_sweep_high  <= RST_SWEEP_HIGH;
            r_fresh_tmo   <= RST_FRESH_TMO;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PULSE_WIDTH: r_pulse_width <= i_cfg_data;
                CFG_CHIME_LOW:   r_chime_low   <= i_cfg_data;
                CFG_CHIME_MID:   r_chime_mid   <= i_cfg_data;
                CFG_CHIME_HIGH:  r_chime_high  <= i_cfg_data;
                CFG_SWEEP_LOW:   r_sweep_low   <= i_cfg_data;
                CFG_SWEEP_MID:   r_sweep_mid   <= i_cfg_data;
                CFG_SWEEP_HIGH:  r_sweep_high  <= i_cfg_data;
                CFG_FRESH_TMO:   r_fresh_tmo   <= i_cfg_data;
                default:         r_fresh_tmo   <= r_fresh_tmo;
            endcase
        end
    end

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action    <= t_action'(i_action);
            r_now       <= i_now_ms;
            r_bus       <= i_bus_number;
            r_id        <= i_frame_id;
            r_len       <= i_frame_length;
            r_flags_in  <= i_status_flags;
            r_risk_in   <= i_risk_level;
            r_front_in  <= i_front_cm;
            r_rear_in   <= i_rear_cm;
            r_faults_in <= i_fault_bits;
        end
    end

    // Update scheduler state step by step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have         <= 1'b0;
            r_risk         <= 8'd0;
            r_flags        <= 8'd0;
            r_front        <= 8'd0;
            r_rear         <= 8'd0;
            r_faults       <= 8'd0;
            r_sticky       <= 8'd0;
            r_alert_state  <= ALERT_NONE;
            r_last_time    <= 32'd0;
            r_next_pulse   <= 32'd0;
            r_pulse_end    <= 32'd0;
            r_pulse_active <= 1'b0;
            r_next_frame   <= 32'd0;
            r_sweep        <= 8'd0;
            r_was_alert    <= 1'b0;
            r_alert        <= 1'b0;
            r_burst        <= '0;
        end else begin
            if (i_cmd.load) begin
                r_burst <= '0;
            end

            // latch the alerting decision for this tick
            if (i_cmd.check) begin
                r_alert <= alert_now;
            end

            // advance the chime pulse
            if (i_cmd.pulse) begin
                if (r_alert) begin
                    r_alert_state <= (r_risk >= RISK_DANGER) ? ALERT_DANGER : ALERT_WARN;
                    if (!pa_kept && np_hit) begin
                        r_pulse_active <= 1'b1;
                        r_pulse_end    <= r_now + {16'd0, r_pulse_width};
                        r_next_pulse   <= r_now + {16'd0, chime_per};
                    end else begin
                        r_pulse_active <= pa_kept;
                        r_next_pulse   <= np_eff;
                    end
                    r_was_alert  <= 1'b1;
                    r_next_frame <= (r_next_frame == 32'd0) ? r_now : r_next_frame;
                end else begin
                    r_pulse_active <= 1'b0;
                    r_next_pulse   <= 32'd0;
                    r_pulse_end    <= 32'd0;
                    r_alert_state  <= ALERT_NONE;
                end
            end

            // drop the frame schedule once alerting stops
            if (rel_go) begin
                r_was_alert  <= 1'b0;
                r_next_frame <= 32'd0;
                r_sweep      <= 8'd0;
            end

            // advance the sweep for each frame sent
            if (frame_emit) begin
                r_sweep      <= r_sweep + 8'd1;
                r_next_frame <= r_next_frame + {16'd0, sweep_per};
                r_burst      <= r_burst + BW'(1);
            end

            // resync a schedule that fell behind
            if (i_cmd.fix && nf_hit) begin
                r_next_frame <= r_now + {16'd0, sweep_per};
            end

            // take a status frame or clear the sticky map
            if (i_cmd.apply) begin
                if (r_action == ACT_STATUS && match) begin
                    r_have        <= 1'b1;
                    r_flags       <= r_flags_in;
                    r_risk        <= r_risk_in;
                    r_front       <= r_front_in;
                    r_rear        <= r_rear_in;
                    r_faults      <= r_faults_in;
                    r_alert_state <= ALERT_NONE;
                    r_last_time   <= r_now;
                    r_sticky      <= r_sticky | r_faults_in |
                                     (sensor ? FORCED_FAULT_BITS : 8'd0);
                    if (r_risk_in >= RISK_WARN &&
                        (r_risk != r_risk_in || r_next_pulse == 32'd0)) begin
                        r_next_pulse <= r_now;
                    end
                end else if (r_action == ACT_CLEAR) begin
                    r_sticky <= 8'd0;
                end
            end
        end
    end

    // Output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the output word
    always_ff @(posedge i_clk) begin
        if (emit) begin
            if (snap_emit) begin
                r_out_kind   <= KIND_SNAP;
                r_out_chime  <= r_pulse_active;
                r_out_sweep  <= 8'd0;
                r_out_last   <= 1'b1;
                r_out_have   <= r_have;
                r_out_risk   <= r_risk;
                r_out_flags  <= r_flags;
                r_out_alert  <= r_alert_state;
                r_out_sticky <= r_sticky;
                r_out_faults <= r_faults;
                r_out_front  <= r_front;
                r_out_rear   <= r_rear;
            end else begin
                r_out_kind   <= KIND_FRAME;
                r_out_chime  <= frame_emit ? r_pulse_active : 1'b0;
                r_out_sweep  <= frame_emit ? r_sweep : 8'd0;
                r_out_last   <= 1'b0;
                r_out_have   <= 1'b0;
                r_out_risk   <= 8'd0;
                r_out_flags  <= 8'd0;
                r_out_alert  <= ALERT_NONE;
                r_out_sticky <= 8'd0;
                r_out_faults <= 8'd0;
                r_out_front  <= 8'd0;
                r_out_rear   <= 8'd0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_result_kind   = r_out_kind;
    assign o_chime_on      = r_out_chime;
    assign o_sweep_value   = r_out_sweep;
    assign o_last_of_run   = r_out_last;
    assign o_status_valid  = r_out_have;
    assign o_risk_out      = r_out_risk;
    assign o_flags_out     = r_out_flags;
    assign o_alert_class   = r_out_alert;
    assign o_sticky_faults = r_out_sticky;
    assign o_active_faults = r_out_faults;
    assign o_front_cm_out  = r_out_front;
    assign o_rear_cm_out   = r_out_rear;

    // The burst counter never runs past its limit
    a_burst_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_burst <= BW'(MAX_BURST))
        else $error("burst count exceeded limit");

    // Each sent chime frame advances the sweep byte by one
    a_sweep_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (frame_emit && i_rst_n) |=> (r_sweep == $past(r_sweep) + 8'd1))
        else $error("sweep byte did not advance with frame");

    // A release frame leaves the frame schedule cleared
    a_release_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rel_emit && i_rst_n) |=> (!r_was_alert && r_sweep == 8'd0 && r_next_frame == 32'd0))
        else $error("release frame did not clear frame schedule");

endmodule

FILE: hw/rtl/safety_chime_pulse_scheduler_unit.sv
// A tick runs the check and pulse steps, then the frame loop and fixup step when alerting
// (one frame word per cycle while output is free), else the release step; then a snapshot.
// Status words and clears run the apply step, then the snapshot; others only the snapshot.
// Throughput: one word at a time, set by the controller's step sequence and frame loop.
// Reset: synchronous active-low i_rst_n clears control and schedule state, reloads config defaults.
// Config writes are taken in any cycle; the block accepts words right after reset.
module safety_chime_pulse_scheduler_unit
    import scps_pkg::*;
#(
    parameter int MAX_BURST = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_now_ms,
    input  logic [1:0]  i_bus_number,
    input  logic [10:0] i_frame_id,
    input  logic [3:0]  i_frame_length,
    input  logic [7:0]  i_status_flags,
    input  logic [7:0]  i_risk_level,
    input  logic [7:0]  i_front_cm,
    input  logic [7:0]  i_rear_cm,
    input  logic [7:0]  i_fault_bits,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic        o_chime_on,
    output logic [7:0]  o_sweep_value,
    output logic        o_last_of_run,
    output logic        o_status_valid,
    output logic [7:0]  o_risk_out,
    output logic [7:0]  o_flags_out,
    output logic [1:0]  o_alert_class,
    output logic [7:0]  o_sticky_faults,
    output logic [7:0]  o_active_faults,
    output logic [7:0]  o_front_cm_out,
    output logic [7:0]  o_rear_cm_out
);

    t_cmd cmd;
    t_sts sts;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    scps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    scps_dp #(
        .MAX_BURST (MAX_BURST)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_action        (i_action),
        .i_now_ms        (i_now_ms),
        .i_bus_number    (i_bus_number),
        .i_frame_id      (i_frame_id),
        .i_frame_length  (i_frame_length),
        .i_status_flags  (i_status_flags),
        .i_risk_level    (i_risk_level),
        .i_front_cm      (i_front_cm),
        .i_rear_cm       (i_rear_cm),
        .i_fault_bits    (i_fault_bits),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_kind   (o_result_kind),
        .o_chime_on      (o_chime_on),
        .o_sweep_value   (o_sweep_value),
        .o_last_of_run   (o_last_of_run),
        .o_status_valid  (o_status_valid),
        .o_risk_out      (o_risk_out),
        .o_flags_out     (o_flags_out),
        .o_alert_class   (o_alert_class),
        .o_sticky_faults (o_sticky_faults),
        .o_active_faults (o_active_faults),
        .o_front_cm_out  (o_front_cm_out),
        .o_rear_cm_out   (o_rear_cm_out)
    );

endmodule
